/* design/i2cmbe_pkg.sv */
// ============================================================================
// i2cmbe_pkg
// Shared types and constants for the tick-driven I2C master byte engine.
// ============================================================================
package i2cmbe_pkg;

    localparam int TICK_COUNTER_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SETUP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HALF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_HALF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CHECK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO   = 3'd4;

    localparam logic [15:0] SETUP_RST     = 16'd4;
    localparam logic [15:0] BIT_HALF_RST  = 16'd5;
    localparam logic [15:0] ACK_HALF_RST  = 16'd2;
    localparam logic [15:0] ACK_CHECK_RST = 16'd1;
    localparam logic [7:0]  ACK_TMO_RST   = 8'd250;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [14:0] {
        PH_IDLE    = 15'b000000000000001,
        PH_ST1     = 15'b000000000000010,
        PH_ST2     = 15'b000000000000100,
        PH_SP1     = 15'b000000000001000,
        PH_SP2     = 15'b000000000010000,
        PH_SP3     = 15'b000000000100000,
        PH_WB_LO   = 15'b000000001000000,
        PH_WB_HI   = 15'b000000010000000,
        PH_WA_LO   = 15'b000000100000000,
        PH_WA_HI   = 15'b000001000000000,
        PH_WA_POLL = 15'b000010000000000,
        PH_RB_LO   = 15'b000100000000000,
        PH_RB_HI   = 15'b001000000000000,
        PH_RA_LO   = 15'b010000000000000,
        PH_RA_HI   = 15'b100000000000000
    } t_phase;

    typedef struct packed {
        logic [15:0] setup_ticks;
        logic [15:0] bit_half_ticks;
        logic [15:0] ack_half_ticks;
        logic [15:0] ack_check_ticks;
        logic [7:0]  ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } t_result;

endpackage

/* design/i2cmbe_core.sv */
// ============================================================================
// i2cmbe_core
// Bus phase sequencer: state registers and the per-tick next-state logic.
// ============================================================================
module i2cmbe_core
    import i2cmbe_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_cfg       i_cfg,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_to_send,
    input  logic       i_sda_in,
    output t_result    o_result
);

    localparam int TW = TICK_COUNTER_BITS;
    localparam int HW = (TW < 16) ? TW : 16;
    localparam logic [TW-1:0] ONE = TW'(1);

    t_phase        r_phase,   n_phase;
    logic [3:0]    r_bit_cnt, n_bit_cnt;
    logic [7:0]    r_tx,      n_tx;
    logic [7:0]    r_rx,      n_rx;
    logic [TW-1:0] r_wait,    n_wait;
    logic [7:0]    r_tmo,     n_tmo;
    logic          r_ack,     n_ack;
    logic          r_nack,    n_nack;
    logic          r_scl,     n_scl;
    logic          r_sda,     n_sda;
    logic          r_drv,     n_drv;
    logic          done;
    logic [3:0]    bit_inc;

    logic [TW-1:0] h_setup, h_bit, h_ack_half, h_ack_chk;

    function automatic logic [TW-1:0] hold_of(input logic [15:0] v);
        logic [TW-1:0] m;
        m = TW'(v[HW-1:0]);
        return (m == '0) ? ONE : m;
    endfunction

    assign h_setup    = hold_of(i_cfg.setup_ticks);
    assign h_bit      = hold_of(i_cfg.bit_half_ticks);
    assign h_ack_half = hold_of(i_cfg.ack_half_ticks);
    assign h_ack_chk  = hold_of(i_cfg.ack_check_ticks);
    assign bit_inc    = r_bit_cnt + 4'd1;

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_wait    = r_wait;
        n_tmo     = r_tmo;
        n_ack     = r_ack;
        n_nack    = r_nack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drv     = r_drv;
        done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (i_mode)
                MODE_START: begin
                    n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                    n_wait = h_setup; n_phase = PH_ST1;
                end
                MODE_STOP: begin
                    n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_wait = h_setup; n_phase = PH_SP1;
                end
                MODE_WRITE: begin
                    n_nack = 1'b0; n_drv = 1'b1; n_scl = 1'b0;
                    n_bit_cnt = '0;
                    n_sda = i_tx_byte[7];
                    n_tx = {i_tx_byte[6:0], 1'b0};
                    n_wait = h_bit; n_phase = PH_WB_LO;
                end
                MODE_READ: begin
                    n_drv = 1'b0; n_sda = 1'b1; n_scl = 1'b0;
                    n_bit_cnt = '0; n_ack = i_ack_to_send;
                    n_wait = h_bit; n_phase = PH_RB_LO;
                end
                default: begin
                end
            endcase
        end else if (r_phase == PH_WA_POLL) begin
            if (!i_sda_in) begin
                n_scl = 1'b0; n_nack = 1'b0;
                n_phase = PH_IDLE; done = 1'b1;
            end else if (r_tmo >= i_cfg.ack_timeout) begin
                n_nack = 1'b1;
                n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                n_wait = h_setup; n_phase = PH_SP1;
            end else begin
                n_tmo = r_tmo + 8'd1;
            end
        end else if (r_wait > ONE) begin
            n_wait = r_wait - ONE;
        end else begin
            case (r_phase)
                PH_ST1: begin
                    n_sda = 1'b0; n_wait = h_setup; n_phase = PH_ST2;
                end
                PH_ST2: begin
                    n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                end
                PH_SP1: begin
                    n_scl = 1'b1; n_wait = h_setup; n_phase = PH_SP2;
                end
                PH_SP2: begin
                    n_sda = 1'b1; n_wait = h_setup; n_phase = PH_SP3;
                end
                PH_SP3: begin
                    n_phase = PH_IDLE; done = 1'b1;
                end
                PH_WB_LO: begin
                    n_scl = 1'b1; n_wait = h_bit; n_phase = PH_WB_HI;
                end
                PH_WB_HI: begin
                    n_scl = 1'b0; n_bit_cnt = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_drv = 1'b0; n_sda = 1'b1;
                        n_wait = h_ack_chk; n_phase = PH_WA_LO;
                    end else begin
                        n_sda = r_tx[7]; n_tx = {r_tx[6:0], 1'b0};
                        n_wait = h_bit; n_phase = PH_WB_LO;
                    end
                end
                PH_WA_LO: begin
                    n_scl = 1'b1; n_wait = h_ack_chk; n_phase = PH_WA_HI;
                end
                PH_WA_HI: begin
                    n_tmo = '0; n_phase = PH_WA_POLL;
                end
                PH_RB_LO: begin
                    n_scl = 1'b1; n_rx = {r_rx[6:0], i_sda_in};
                    n_wait = h_bit; n_phase = PH_RB_HI;
                end
                PH_RB_HI: begin
                    n_scl = 1'b0; n_bit_cnt = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_drv = 1'b1; n_sda = ~r_ack;
                        n_wait = h_ack_half; n_phase = PH_RA_LO;
                    end else begin
                        n_wait = h_bit; n_phase = PH_RB_LO;
                    end
                end
                PH_RA_LO: begin
                    n_scl = 1'b1; n_wait = h_ack_half; n_phase = PH_RA_HI;
                end
                PH_RA_HI: begin
                    n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_tx      <= '0;
            r_rx      <= '0;
            r_wait    <= '0;
            r_tmo     <= '0;
            r_ack     <= 1'b0;
            r_nack    <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_drv     <= 1'b1;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_wait    <= n_wait;
            r_tmo     <= n_tmo;
            r_ack     <= n_ack;
            r_nack    <= n_nack;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_drv     <= n_drv;
        end
    end

    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.sda_drive = n_drv;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_rx;
        o_result.nack_seen = n_nack;
    end

    ap_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    ap_poll_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WA_POLL) |-> (!r_drv && r_scl))
        else $error("ACK poll without released SDA and high SCL");

    ap_idle_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_phase != PH_WA_POLL) |-> (r_wait != '0))
        else $error("active phase with zero hold count");

endmodule

/* design/i2c_master_byte_engine_unit.sv */
// ============================================================================
// i2c_master_byte_engine_unit
// Tick-driven I2C master: START, STOP, byte write with ACK poll, byte read.
// ============================================================================
// Each accepted input transaction is one bus timing tick and yields exactly one
// result transaction with the SCL/SDA drive levels and status after that tick.
// The engine takes one transaction per clock unless the result is stalled: the
// phase sequencer updates in a single pass and the result lands in an output
// register in the cycle after acceptance, so throughput is one tick per cycle
// while the result side takes one per cycle. A command in mode is only taken on
// a tick where the engine is idle. Hold times are counted in ticks, not clocks.
module i2c_master_byte_engine_unit
    import i2cmbe_pkg::*;
#(
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_mode,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_ack_to_send,
    input  logic                  i_sda_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_scl_level,
    output logic                  o_sda_level,
    output logic                  o_sda_drive,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rx_byte,
    output logic                  o_nack_seen
);

    t_cfg    r_cfg;
    t_result r_res, n_res;
    logic    r_out_valid;
    logic    accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_ticks     <= SETUP_RST;
            r_cfg.bit_half_ticks  <= BIT_HALF_RST;
            r_cfg.ack_half_ticks  <= ACK_HALF_RST;
            r_cfg.ack_check_ticks <= ACK_CHECK_RST;
            r_cfg.ack_timeout     <= ACK_TMO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETUP:     r_cfg.setup_ticks     <= i_cfg_data;
                CFG_BIT_HALF:  r_cfg.bit_half_ticks  <= i_cfg_data;
                CFG_ACK_HALF:  r_cfg.ack_half_ticks  <= i_cfg_data;
                CFG_ACK_CHECK: r_cfg.ack_check_ticks <= i_cfg_data;
                CFG_ACK_TMO:   r_cfg.ack_timeout     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    i2cmbe_core #(
        .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_cfg        (r_cfg),
        .i_mode       (i_mode),
        .i_tx_byte    (i_tx_byte),
        .i_ack_to_send(i_ack_to_send),
        .i_sda_in     (i_sda_in),
        .o_result     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_res.scl_level;
    assign o_sda_level = r_res.sda_level;
    assign o_sda_drive = r_res.sda_drive;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_rx_byte   = r_res.rx_byte;
    assign o_nack_seen = r_res.nack_seen;

    ap_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_done_res && o_busy_res))
        else $error("done and busy in the same result");

    ap_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sda_drive) |-> o_sda_level)
        else $error("released SDA reported low");

    ap_rose_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without an accepted transaction");

    ap_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

endmodule
